// ----- design/usb_control_endpoint_responder_macros.svh -----
// Assertion macros used by the port-level checker of the endpoint-0 responder.
`ifndef USB_CONTROL_ENDPOINT_RESPONDER_MACROS_SVH
`define USB_CONTROL_ENDPOINT_RESPONDER_MACROS_SVH

// Checked property that is held off while reset is high.
`define UCER_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ucer check failed");

// Checked property that also holds during reset.
`define UCER_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ucer check failed");

`endif

// ----- design/ucer_pkg.sv -----
// Package with types, codes and the descriptor table of the endpoint-0 responder.
`timescale 1ns / 1ps
package ucer_pkg;

  localparam int EP0_PACKET_SIZE = 64;
  localparam int ROM_BYTES = 318;

  // Event codes.
  localparam logic [2:0] CMD_SETUP   = 3'd0;
  localparam logic [2:0] CMD_IN_DONE = 3'd1;
  localparam logic [2:0] CMD_OUT     = 3'd2;
  localparam logic [2:0] CMD_BUS_RST = 3'd3;
  localparam logic [2:0] CMD_SUSPEND = 3'd4;

  // Handshake codes.
  localparam logic [1:0] HS_NAK   = 2'd0;
  localparam logic [1:0] HS_ACK   = 2'd1;
  localparam logic [1:0] HS_STALL = 2'd2;

  // Request codes.
  localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
  localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
  localparam logic [7:0] REQ_GET_DESC      = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
  localparam logic [7:0] REQ_GET_IFACE     = 8'h0A;

  // Descriptor types.
  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_REPORT = 8'h22;

  // Endpoint addresses for clear feature.
  localparam logic [7:0] EP1_IN  = 8'h81;
  localparam logic [7:0] EP1_OUT = 8'h01;
  localparam logic [7:0] EP2_IN  = 8'h82;
  localparam logic [7:0] EP2_OUT = 8'h02;

  // Descriptor offsets and lengths.
  localparam logic [8:0] OFF_DEV  = 9'd0;
  localparam logic [8:0] OFF_CFG  = 9'd18;
  localparam logic [8:0] OFF_REP  = 9'd75;
  localparam logic [8:0] OFF_LANG = 9'd284;
  localparam logic [8:0] OFF_MANU = 9'd288;
  localparam logic [8:0] OFF_PROD = 9'd302;
  localparam logic [15:0] LEN_DEV  = 16'd18;
  localparam logic [15:0] LEN_CFG  = 16'd57;
  localparam logic [15:0] LEN_REP  = 16'd209;
  localparam logic [15:0] LEN_LANG = 16'd4;
  localparam logic [15:0] LEN_MANU = 16'd14;
  localparam logic [15:0] LEN_PROD = 16'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHOW
  } ucer_state_t;

  // Where packet bytes come from.
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ROM,
    SRC_CFG
  } ucer_src_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic exec;
    logic load;
  } ucer_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic last;
  } ucer_status_t;

  typedef logic [3:0][7:0] ucer_ids_t;

  localparam logic [7:0] DESC_ROM [ROM_BYTES] = '{
    8'h12,8'h01,8'h10,8'h01,8'h00,8'h00,8'h00,8'h00,8'h4A,8'h43,8'h40,8'h55,8'h01,8'h01,
    8'h01,8'h02,8'h00,8'h01,
    8'h09,8'h02,8'h39,8'h00,8'h02,8'h01,8'h00,8'hA0,8'h32,
    8'h09,8'h04,8'h00,8'h00,8'h01,8'h03,8'h00,8'h00,8'h00,
    8'h09,8'h21,8'h11,8'h01,8'h00,8'h01,8'h22,8'hD1,8'h00,
    8'h07,8'h05,8'h81,8'h03,8'h40,8'h00,8'h0A,
    8'h09,8'h04,8'h01,8'h00,8'h02,8'h00,8'h00,8'h00,8'h00,
    8'h07,8'h05,8'h82,8'h02,8'h40,8'h00,8'h00,
    8'h07,8'h05,8'h02,8'h02,8'h40,8'h00,8'h00,
    8'h05,8'h01,8'h09,8'h06,8'hA1,8'h01,8'h85,8'h00,
    8'h05,8'h07,8'h19,8'hE0,8'h29,8'hE7,8'h15,8'h00,8'h25,8'h01,8'h75,8'h01,
    8'h95,8'h08,8'h81,8'h02,8'h95,8'h01,8'h75,8'h08,8'h81,8'h01,8'h95,8'h03,
    8'h75,8'h01,8'h05,8'h08,8'h19,8'h01,8'h29,8'h03,8'h91,8'h02,8'h95,8'h05,
    8'h75,8'h01,8'h91,8'h01,8'h95,8'h06,8'h75,8'h08,8'h26,8'hFF,8'h00,8'h05,
    8'h07,8'h19,8'h00,8'h29,8'h91,8'h81,8'h00,8'hC0,
    8'h05,8'h01,8'h09,8'h02,8'hA1,8'h01,8'h85,8'h00,
    8'h09,8'h01,8'hA1,8'h00,8'h05,8'h09,8'h19,8'h01,8'h29,8'h03,8'h15,8'h00,
    8'h25,8'h01,8'h75,8'h01,8'h95,8'h03,8'h81,8'h02,8'h75,8'h05,8'h95,8'h01,
    8'h81,8'h01,8'h05,8'h01,8'h09,8'h30,8'h09,8'h31,8'h09,8'h38,8'h15,8'h81,
    8'h25,8'h7F,8'h75,8'h08,8'h95,8'h03,8'h81,8'h06,8'hC0,8'hC0,
    8'h05,8'h0C,8'h09,8'h01,8'hA1,8'h01,8'h85,8'h00,
    8'h09,8'hB0,8'h09,8'hB5,8'h09,8'hB6,8'h09,8'hE9,8'h09,8'hEA,8'h09,8'hE2,
    8'h09,8'hB1,8'h09,8'hB7,8'h15,8'h00,8'h25,8'h01,8'h95,8'h08,8'h75,8'h01,
    8'h81,8'h02,8'hC0,
    8'h05,8'h01,8'h09,8'h0E,8'hA1,8'h01,8'h85,8'h00,
    8'h05,8'h0D,8'h09,8'h21,8'hA1,8'h00,8'h05,8'h09,8'h09,8'h01,8'h95,8'h01,
    8'h75,8'h01,8'h15,8'h00,8'h25,8'h01,8'h81,8'h02,8'h05,8'h01,8'h09,8'h37,
    8'h95,8'h01,8'h75,8'h0F,8'h55,8'h0F,8'h65,8'h14,8'h36,8'hF0,8'hF1,8'h46,
    8'h10,8'h0E,8'h16,8'hF0,8'hF1,8'h26,8'h10,8'h0E,8'h81,8'h06,8'hC0,8'hC0,
    8'h04,8'h03,8'h09,8'h04,
    8'h0E,8'h03,8'h6C,8'h00,8'h61,8'h00,8'h62,8'h00,8'h34,8'h00,8'h31,8'h00,8'h38,8'h00,
    8'h10,8'h03,8'h54,8'h00,8'h50,8'h00,8'h37,8'h00,8'h38,8'h00,8'h52,8'h00,8'h63,8'h00,
    8'h76,8'h00
  };

  // One descriptor byte, with the packet size and report ids patched in.
  function automatic logic [7:0] rom_byte(input logic [8:0] a, input ucer_ids_t ids);
    logic [7:0] b;
    if (a == OFF_DEV + 9'd7) b = 8'(EP0_PACKET_SIZE);
    else if (a == OFF_REP + 9'd7) b = ids[0];
    else if (a == OFF_REP + 9'd71) b = ids[1];
    else if (a == OFF_REP + 9'd125) b = ids[2];
    else if (a == OFF_REP + 9'd160) b = ids[3];
    else if (a >= 9'(ROM_BYTES)) b = 8'd0;
    else b = DESC_ROM[a];
    return b;
  endfunction

  // Bytes of the next packet for a given remaining length.
  function automatic logic [6:0] pkt_size(input logic [15:0] rem);
    return (rem < 16'(EP0_PACKET_SIZE)) ? rem[6:0] : 7'(EP0_PACKET_SIZE);
  endfunction

endpackage

// ----- design/usb_control_endpoint_responder.sv -----
// A request is taken when idle; the load state registers its first result, shown in the show state.
// Each result of a packet then follows one per cycle while the output is not stalled.
// One request yields max(1, packet bytes) results, up to 64.
// A new request is taken only after the last result of the previous one is delivered.
// Synchronous reset restores report ids 1 to 4, address 0, nak and ack handshakes.
`timescale 1ns / 1ps
module usb_control_endpoint_responder import ucer_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_index,
  input  logic [15:0] request_length,
  input  logic [7:0]  out_report_byte,
  input  logic        suspended,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  tx_handshake,
  output logic [1:0]  rx_handshake,
  output logic [6:0]  tx_length,
  output logic        tx_toggle,
  output logic [7:0]  data_byte,
  output logic        last,
  output logic [6:0]  device_address,
  output logic        led_num,
  output logic        led_caps,
  output logic        led_update,
  output logic        bus_resumed,
  output logic [2:0]  endpoint_reset
);

  ucer_cmd_t    cmd;
  ucer_status_t status;

  // Sequencer.
  ucer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Decode, state and output register.
  ucer_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .command         (command),
    .request_type    (request_type),
    .request_code    (request_code),
    .request_value   (request_value),
    .request_index   (request_index),
    .request_length  (request_length),
    .out_report_byte (out_report_byte),
    .suspended       (suspended),
    .tx_handshake    (tx_handshake),
    .rx_handshake    (rx_handshake),
    .tx_length       (tx_length),
    .tx_toggle       (tx_toggle),
    .data_byte       (data_byte),
    .last            (last),
    .device_address  (device_address),
    .led_num         (led_num),
    .led_caps        (led_caps),
    .led_update      (led_update),
    .bus_resumed     (bus_resumed),
    .endpoint_reset  (endpoint_reset)
  );

endmodule

// ----- design/ucer_ctrl.sv -----
// Controller state machine: takes requests and sequences the packet bytes out.
`timescale 1ns / 1ps
module ucer_ctrl import ucer_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output ucer_cmd_t    cmd,
  input  ucer_status_t status
);

  ucer_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.exec = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (status.last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- design/ucer_datapath.sv -----
// Datapath: request decode, device state, report ids and the output register.
`timescale 1ns / 1ps
module ucer_datapath import ucer_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ucer_cmd_t    cmd,
  output ucer_status_t status,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  input  logic [2:0]   command,
  input  logic [7:0]   request_type,
  input  logic [7:0]   request_code,
  input  logic [15:0]  request_value,
  input  logic [15:0]  request_index,
  input  logic [15:0]  request_length,
  input  logic [7:0]   out_report_byte,
  input  logic         suspended,
  output logic [1:0]   tx_handshake,
  output logic [1:0]   rx_handshake,
  output logic [6:0]   tx_length,
  output logic         tx_toggle,
  output logic [7:0]   data_byte,
  output logic         last,
  output logic [6:0]   device_address,
  output logic         led_num,
  output logic         led_caps,
  output logic         led_update,
  output logic         bus_resumed,
  output logic [2:0]   endpoint_reset
);

  // Device state.
  ucer_ids_t   ids;
  logic [7:0]  active_request;
  logic [15:0] remaining_length;
  logic [8:0]  descriptor_offset;
  logic [6:0]  pending_address;
  logic [7:0]  configuration_value;
  logic [6:0]  address_register;
  logic        toggle_bit;
  logic [1:0]  led_bits;
  logic        ready_flag;
  logic [1:0]  tx_hs, rx_hs;

  // Per-request packet context.
  logic [6:0]  pkt_len;
  logic [8:0]  pkt_base;
  ucer_src_t   pkt_src;
  logic [6:0]  byte_idx;
  logic        led_upd;
  logic [2:0]  ep_rst;

  // Next values from the decode.
  logic [7:0]  active_request_next;
  logic [15:0] remaining_length_next;
  logic [8:0]  descriptor_offset_next;
  logic [6:0]  pending_address_next;
  logic [7:0]  configuration_value_next;
  logic [6:0]  address_register_next;
  logic        toggle_bit_next;
  logic [1:0]  led_bits_next;
  logic        ready_flag_next;
  logic [1:0]  tx_hs_next, rx_hs_next;
  logic [6:0]  pkt_len_next;
  logic [8:0]  pkt_base_next;
  ucer_src_t   pkt_src_next;
  logic        led_upd_next;
  logic [2:0]  ep_rst_next;

  // Request decode.
  always_comb begin
    logic        err;
    logic [8:0]  start;
    logic [15:0] dlen;
    logic [15:0] clip;
    logic [6:0]  first;
    logic [6:0]  n;
    err = 1'b0;
    start = OFF_DEV;
    dlen = '0;
    clip = '0;
    first = '0;
    n = '0;
    active_request_next = active_request;
    remaining_length_next = remaining_length;
    descriptor_offset_next = descriptor_offset;
    pending_address_next = pending_address;
    configuration_value_next = configuration_value;
    address_register_next = address_register;
    toggle_bit_next = toggle_bit;
    led_bits_next = led_bits;
    ready_flag_next = ready_flag;
    tx_hs_next = tx_hs;
    rx_hs_next = rx_hs;
    pkt_len_next = '0;
    pkt_base_next = pkt_base;
    pkt_src_next = SRC_ZERO;
    led_upd_next = 1'b0;
    ep_rst_next = '0;

    unique case (command)
      CMD_SETUP: begin
        active_request_next = request_code;
        remaining_length_next = request_length;
        toggle_bit_next = 1'b1;
        if (request_type[6:5] != 2'd0) begin
          if (request_code != REQ_SET_CONFIG && request_code != REQ_GET_IFACE) err = 1'b1;
        end else begin
          unique case (request_code)
            REQ_GET_DESC: begin
              unique case (request_value[15:8])
                DT_DEVICE: begin start = OFF_DEV; dlen = LEN_DEV; end
                DT_CONFIG: begin start = OFF_CFG; dlen = LEN_CFG; end
                DT_REPORT: begin
                  if (request_index[7:0] == 8'd0) begin
                    start = OFF_REP;
                    dlen = LEN_REP;
                  end else begin
                    err = 1'b1;
                  end
                end
                DT_STRING: begin
                  unique case (request_value[7:0])
                    8'd0: begin start = OFF_LANG; dlen = LEN_LANG; end
                    8'd1: begin start = OFF_MANU; dlen = LEN_MANU; end
                    8'd2: begin start = OFF_PROD; dlen = LEN_PROD; end
                    default: err = 1'b1;
                  endcase
                end
                default: err = 1'b1;
              endcase
              if (!err) begin
                clip = (request_length > dlen) ? dlen : request_length;
                remaining_length_next = clip;
                first = pkt_size(clip);
                descriptor_offset_next = start + 9'(first);
                pkt_base_next = start;
                pkt_src_next = SRC_ROM;
              end
            end
            REQ_SET_ADDRESS: pending_address_next = request_value[6:0];
            REQ_GET_CONFIG: begin
              pkt_src_next = SRC_CFG;
              if (request_length > 16'd1) remaining_length_next = 16'd1;
            end
            REQ_SET_CONFIG: configuration_value_next = request_value[7:0];
            REQ_CLEAR_FEATURE: begin
              if (request_type[4:0] == 5'd2) begin
                unique case (request_index[7:0])
                  EP1_IN:  ep_rst_next = 3'd1;
                  EP1_OUT: ep_rst_next = 3'd2;
                  EP2_IN:  ep_rst_next = 3'd3;
                  EP2_OUT: ep_rst_next = 3'd4;
                  default: err = 1'b1;
                endcase
              end else begin
                err = 1'b1;
              end
            end
            REQ_GET_IFACE: begin
              if (request_length > 16'd1) remaining_length_next = 16'd1;
            end
            REQ_GET_STATUS: begin
              if (request_length > 16'd2) remaining_length_next = 16'd2;
            end
            default: err = 1'b1;
          endcase
        end
        if (err) begin
          tx_hs_next = HS_STALL;
          rx_hs_next = HS_STALL;
          remaining_length_next = '0;
          ep_rst_next = '0;
          pkt_src_next = SRC_ZERO;
        end else begin
          if (request_type[7]) begin
            n = pkt_size(remaining_length_next);
            remaining_length_next = remaining_length_next - 16'(n);
          end
          pkt_len_next = n;
          tx_hs_next = HS_ACK;
          rx_hs_next = HS_ACK;
        end
      end
      CMD_IN_DONE: begin
        if (active_request == REQ_GET_DESC) begin
          n = pkt_size(remaining_length);
          pkt_len_next = n;
          pkt_base_next = descriptor_offset;
          pkt_src_next = SRC_ROM;
          remaining_length_next = remaining_length - 16'(n);
          descriptor_offset_next = descriptor_offset + 9'(n);
          toggle_bit_next = ~toggle_bit;
        end else begin
          if (active_request == REQ_SET_ADDRESS) address_register_next = pending_address;
          tx_hs_next = HS_NAK;
          rx_hs_next = HS_ACK;
          toggle_bit_next = 1'b0;
        end
      end
      CMD_OUT: begin
        if (active_request == REQ_SET_CONFIG) begin
          led_bits_next = out_report_byte[1:0];
          led_upd_next = 1'b1;
        end
      end
      CMD_BUS_RST: begin
        address_register_next = '0;
        tx_hs_next = HS_NAK;
        rx_hs_next = HS_ACK;
        toggle_bit_next = 1'b0;
      end
      CMD_SUSPEND: ready_flag_next = ~suspended;
      default: ;
    endcase
  end

  // Control state and report ids.
  always_ff @(posedge clk) begin
    if (rst) begin
      ids <= {8'd4, 8'd3, 8'd2, 8'd1};
      active_request <= '0;
      remaining_length <= '0;
      descriptor_offset <= '0;
      pending_address <= '0;
      configuration_value <= '0;
      address_register <= '0;
      toggle_bit <= 1'b0;
      led_bits <= '0;
      ready_flag <= 1'b0;
      tx_hs <= HS_NAK;
      rx_hs <= HS_ACK;
    end else begin
      if (cfg_write) ids[cfg_index] <= cfg_data;
      if (cmd.exec) begin
        active_request <= active_request_next;
        remaining_length <= remaining_length_next;
        descriptor_offset <= descriptor_offset_next;
        pending_address <= pending_address_next;
        configuration_value <= configuration_value_next;
        address_register <= address_register_next;
        toggle_bit <= toggle_bit_next;
        led_bits <= led_bits_next;
        ready_flag <= ready_flag_next;
        tx_hs <= tx_hs_next;
        rx_hs <= rx_hs_next;
      end
    end
  end

  // Packet context, latched with the request.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pkt_len <= pkt_len_next;
      pkt_base <= pkt_base_next;
      pkt_src <= pkt_src_next;
      led_upd <= led_upd_next;
      ep_rst <= ep_rst_next;
      byte_idx <= '0;
    end else if (cmd.load) begin
      byte_idx <= byte_idx + 7'd1;
    end
  end

  // Byte source and last-byte flag for the current index.
  logic [7:0] cur_byte;
  logic [6:0] count;
  always_comb begin
    count = (pkt_len == 7'd0) ? 7'd1 : pkt_len;
    cur_byte = 8'd0;
    if (pkt_len != 7'd0) begin
      unique case (pkt_src)
        SRC_ROM:  cur_byte = rom_byte(pkt_base + 9'(byte_idx), ids);
        SRC_CFG:  cur_byte = (byte_idx == 7'd0) ? configuration_value : 8'd0;
        default:  cur_byte = 8'd0;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_byte <= cur_byte;
      last <= (byte_idx + 7'd1 == count);
    end
  end

  assign status.last = last;
  assign tx_handshake = tx_hs;
  assign rx_handshake = rx_hs;
  assign tx_length = pkt_len;
  assign tx_toggle = toggle_bit;
  assign device_address = address_register;
  assign led_num = led_bits[0];
  assign led_caps = led_bits[1];
  assign led_update = led_upd;
  assign bus_resumed = ready_flag;
  assign endpoint_reset = ep_rst;

endmodule

// ----- design/ucer_checker.sv -----
// Port-level checks of the endpoint-0 responder and their binding.
`timescale 1ns / 1ps
`include "usb_control_endpoint_responder_macros.svh"
module ucer_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  tx_length,
  input logic [7:0]  data_byte,
  input logic        last
);

  // Reset leaves no result pending.
  `UCER_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid)
  // A taken request keeps the input closed until its results are out.
  `UCER_ASSERT(a_busy_after_take, clk, rst, in_valid && !in_stall |=> in_stall)
  // After the final result the output goes quiet.
  `UCER_ASSERT(a_last_ends, clk, rst, out_valid && last && !out_stall |=> !out_valid)
  // An empty packet is a single zero result.
  `UCER_ASSERT(a_empty_pkt, clk, rst,
    out_valid && tx_length == 7'd0 |-> last && data_byte == 8'd0)

endmodule

bind usb_control_endpoint_responder ucer_checker u_ucer_checker (.*);

// ----- dv/usb_control_endpoint_responder_checker.sv -----
// Checker that predicts and compares the endpoint-0 responder results.
`timescale 1ns / 1ps
module usb_control_endpoint_responder_checker import ucer_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  command,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_index,
  input  logic [15:0] request_length,
  input  logic [7:0]  out_report_byte,
  input  logic        suspended,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  tx_handshake,
  input  logic [1:0]  rx_handshake,
  input  logic [6:0]  tx_length,
  input  logic        tx_toggle,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic [6:0]  device_address,
  input  logic        led_num,
  input  logic        led_caps,
  input  logic        led_update,
  input  logic        bus_resumed,
  input  logic [2:0]  endpoint_reset,
  output int          fail_count,
  output int          packets_due
);

  typedef struct packed {
    logic [1:0] tx_hs;
    logic [1:0] rx_hs;
    logic [6:0] len;
    logic       toggle;
    logic [7:0] data;
    logic       final_byte;
    logic [6:0] addr;
    logic       num;
    logic       caps;
    logic       led_wr;
    logic       ready;
    logic [2:0] ep_clear;
  } ep0_beat_t;

  ep0_beat_t  beat_queue[$];
  ucer_ids_t  report_ids;
  logic [7:0]  cur_request;
  logic [15:0] bytes_left;
  logic [8:0]  rom_ptr;
  logic [6:0]  new_address;
  logic [7:0]  config_value;
  logic [6:0]  bus_address;
  logic        data_toggle;
  logic [1:0]  led_state;
  logic        bus_ready;
  logic [1:0]  tx_state;
  logic [1:0]  rx_state;

  assign packets_due = beat_queue.size();

  // Descriptor byte with the packet size and report ids patched in.
  function automatic logic [7:0] desc_byte(input logic [8:0] a);
    if (a == OFF_DEV + 9'd7) return 8'(EP0_PACKET_SIZE);
    if (a == OFF_REP + 9'd7) return report_ids[0];
    if (a == OFF_REP + 9'd71) return report_ids[1];
    if (a == OFF_REP + 9'd125) return report_ids[2];
    if (a == OFF_REP + 9'd160) return report_ids[3];
    if (a >= 9'(ROM_BYTES)) return 8'd0;
    return DESC_ROM[a];
  endfunction

  function automatic int chunk(input logic [15:0] rem);
    return (rem < 16'(EP0_PACKET_SIZE)) ? int'(rem) : EP0_PACKET_SIZE;
  endfunction

  // Works out the packet bytes that one request causes and queues them.
  task automatic predict_packet(input logic [2:0] cmd, input logic [7:0] rt,
                                input logic [7:0] code, input logic [15:0] value,
                                input logic [15:0] index, input logic [15:0] length,
                                input logic [7:0] leds_in, input logic susp);
    logic [7:0]  pkt [EP0_PACKET_SIZE];
    int          n;
    int          first;
    int          count;
    logic [2:0]  ep_clear;
    logic        led_wr;
    logic        err;
    logic [8:0]  start;
    logic [15:0] dlen;
    ep0_beat_t   b;
    for (int i = 0; i < EP0_PACKET_SIZE; i++) pkt[i] = 8'd0;
    n = 0;
    ep_clear = 3'd0;
    led_wr = 1'b0;
    err = 1'b0;
    start = 9'd0;
    dlen = 16'd0;
    case (cmd)
      CMD_SETUP: begin
        cur_request = code;
        bytes_left = length;
        data_toggle = 1'b1;
        if (rt[6:5] != 2'd0) begin
          // Class requests: only set report and set idle are taken.
          if (code != REQ_SET_CONFIG && code != REQ_GET_IFACE) err = 1'b1;
        end else begin
          case (code)
            REQ_GET_DESC: begin
              case (value[15:8])
                DT_DEVICE: begin start = OFF_DEV; dlen = LEN_DEV; end
                DT_CONFIG: begin start = OFF_CFG; dlen = LEN_CFG; end
                DT_REPORT: begin
                  if (index[7:0] == 8'd0) begin
                    start = OFF_REP;
                    dlen = LEN_REP;
                  end else err = 1'b1;
                end
                DT_STRING: begin
                  case (value[7:0])
                    8'd0: begin start = OFF_LANG; dlen = LEN_LANG; end
                    8'd1: begin start = OFF_MANU; dlen = LEN_MANU; end
                    8'd2: begin start = OFF_PROD; dlen = LEN_PROD; end
                    default: err = 1'b1;
                  endcase
                end
                default: err = 1'b1;
              endcase
              if (!err) begin
                if (bytes_left > dlen) bytes_left = dlen;
                first = chunk(bytes_left);
                for (int i = 0; i < first; i++) pkt[i] = desc_byte(9'(start + i));
                rom_ptr = 9'(start + first);
              end
            end
            REQ_SET_ADDRESS: new_address = value[6:0];
            REQ_GET_CONFIG: begin
              pkt[0] = config_value;
              if (bytes_left > 16'd1) bytes_left = 16'd1;
            end
            REQ_SET_CONFIG: config_value = value[7:0];
            REQ_CLEAR_FEATURE: begin
              if (rt[4:0] == 5'd2) begin
                case (index[7:0])
                  EP1_IN:  ep_clear = 3'd1;
                  EP1_OUT: ep_clear = 3'd2;
                  EP2_IN:  ep_clear = 3'd3;
                  EP2_OUT: ep_clear = 3'd4;
                  default: err = 1'b1;
                endcase
              end else err = 1'b1;
            end
            REQ_GET_IFACE: if (bytes_left > 16'd1) bytes_left = 16'd1;
            REQ_GET_STATUS: if (bytes_left > 16'd2) bytes_left = 16'd2;
            default: err = 1'b1;
          endcase
        end
        if (err) begin
          tx_state = HS_STALL;
          rx_state = HS_STALL;
          bytes_left = 16'd0;
        end else begin
          if (rt[7]) begin
            n = chunk(bytes_left);
            bytes_left = bytes_left - 16'(n);
          end
          tx_state = HS_ACK;
          rx_state = HS_ACK;
        end
      end
      CMD_IN_DONE: begin
        if (cur_request == REQ_GET_DESC) begin
          // Next descriptor packet, toggle flipped.
          n = chunk(bytes_left);
          for (int i = 0; i < n; i++) pkt[i] = desc_byte(9'(rom_ptr + i));
          bytes_left = bytes_left - 16'(n);
          rom_ptr = 9'(rom_ptr + n);
          data_toggle = ~data_toggle;
        end else begin
          if (cur_request == REQ_SET_ADDRESS) bus_address = new_address;
          tx_state = HS_NAK;
          rx_state = HS_ACK;
          data_toggle = 1'b0;
        end
      end
      CMD_OUT: begin
        if (cur_request == REQ_SET_CONFIG) begin
          led_state = leds_in[1:0];
          led_wr = 1'b1;
        end
      end
      CMD_BUS_RST: begin
        bus_address = 7'd0;
        tx_state = HS_NAK;
        rx_state = HS_ACK;
        data_toggle = 1'b0;
      end
      CMD_SUSPEND: bus_ready = ~susp;
      default: ;
    endcase
    count = (n == 0) ? 1 : n;
    for (int k = 0; k < count; k++) begin
      b.tx_hs = tx_state;
      b.rx_hs = rx_state;
      b.len = 7'(n);
      b.toggle = data_toggle;
      b.data = (n == 0) ? 8'd0 : pkt[k];
      b.final_byte = (k + 1 == count);
      b.addr = bus_address;
      b.num = led_state[0];
      b.caps = led_state[1];
      b.led_wr = led_wr;
      b.ready = bus_ready;
      b.ep_clear = ep_clear;
      beat_queue.push_back(b);
    end
  endtask

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Predictor state, request intake and result comparison.
  always @(posedge clk) begin
    ep0_beat_t e;
    if (rst) begin
      report_ids = {8'd4, 8'd3, 8'd2, 8'd1};
      cur_request = 8'd0;
      bytes_left = 16'd0;
      rom_ptr = 9'd0;
      new_address = 7'd0;
      config_value = 8'd0;
      bus_address = 7'd0;
      data_toggle = 1'b0;
      led_state = 2'd0;
      bus_ready = 1'b0;
      tx_state = HS_NAK;
      rx_state = HS_ACK;
      beat_queue.delete();
    end else begin
      if (cfg_write) report_ids[cfg_index] = cfg_data;
      if (in_valid && !in_stall) begin
        predict_packet(command, request_type, request_code, request_value,
                       request_index, request_length, out_report_byte, suspended);
      end
      if (out_valid && !out_stall) begin
        if (beat_queue.size() == 0) begin
          $error("result with no request waiting");
          fail_count++;
        end else begin
          e = beat_queue.pop_front();
          check_field("tx_handshake", e.tx_hs, tx_handshake);
          check_field("rx_handshake", e.rx_hs, rx_handshake);
          check_field("tx_length", e.len, tx_length);
          check_field("tx_toggle", e.toggle, tx_toggle);
          check_field("data_byte", e.data, data_byte);
          check_field("last", e.final_byte, last);
          check_field("device_address", e.addr, device_address);
          check_field("led_num", e.num, led_num);
          check_field("led_caps", e.caps, led_caps);
          check_field("led_update", e.led_wr, led_update);
          check_field("bus_resumed", e.ready, bus_resumed);
          check_field("endpoint_reset", e.ep_clear, endpoint_reset);
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

// ----- dv/testbench.sv -----
// Top of the endpoint-0 responder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import ucer_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 160;
  // Request type bytes.
  localparam logic [7:0] RT_DEV_IN = 8'h80;
  localparam logic [7:0] RT_DEV_OUT = 8'h00;
  localparam logic [7:0] RT_EP_OUT = 8'h02;
  localparam logic [7:0] RT_CLASS_IFACE = 8'h21;
  // Class requests share codes with set configuration and get interface.
  localparam logic [7:0] REQ_SET_REPORT = REQ_SET_CONFIG;
  localparam logic [7:0] REQ_SET_IDLE = REQ_GET_IFACE;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  command;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_index;
  logic [15:0] request_length;
  logic [7:0]  out_report_byte;
  logic        suspended;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  tx_handshake;
  logic [1:0]  rx_handshake;
  logic [6:0]  tx_length;
  logic        tx_toggle;
  logic [7:0]  data_byte;
  logic        last;
  logic [6:0]  device_address;
  logic        led_num;
  logic        led_caps;
  logic        led_update;
  logic        bus_resumed;
  logic [2:0]  endpoint_reset;
  int          fail_count;
  int          packets_due;
  int          stall_left;
  int          idle_cycles;
  logic        gaps_on;

  usb_control_endpoint_responder dut (.*);
  usb_control_endpoint_responder_checker checker_i (.*);

  always #5 clk = ~clk;

  // Random output stalls: mostly short, a few long.
  always @(posedge clk) begin
    if (!gaps_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < 25) begin
      stall_left <= ($urandom_range(99) < 8) ? $urandom_range(60, 15) : $urandom_range(2, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one request after a random gap and holds it until accepted.
  task automatic send(input logic [2:0] cmd, input logic [7:0] rt, input logic [7:0] code,
                      input logic [15:0] value, input logic [15:0] index,
                      input logic [15:0] length, input logic [7:0] leds, input logic susp);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(99) < 35)
      gap = ($urandom_range(99) < 10) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    request_type <= rt;
    request_code <= code;
    request_value <= value;
    request_index <= index;
    request_length <= length;
    out_report_byte <= leds;
    suspended <= susp;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic setup_req(input logic [7:0] rt, input logic [7:0] code,
                           input logic [15:0] value, input logic [15:0] index,
                           input logic [15:0] length);
    send(CMD_SETUP, rt, code, value, index, length, 8'($urandom), 1'($urandom));
  endtask

  task automatic plain_event(input logic [2:0] cmd, input logic [7:0] leds, input logic susp);
    send(cmd, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
         leds, susp);
  endtask

  // Report ids are written only once every result is in.
  task automatic write_ids(input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c, input logic [7:0] d);
    logic [7:0] ids [4];
    ids = '{a, b, c, d};
    in_valid <= 1'b0;
    @(posedge clk);
    while (packets_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= ids[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Descriptor fetch followed by a few in-done events.
  task automatic fetch_descriptor(input logic [15:0] value, input logic [15:0] index,
                                  input logic [15:0] length, input int ins);
    setup_req(RT_DEV_IN, REQ_GET_DESC, value, index, length);
    for (int i = 0; i < ins; i++) plain_event(CMD_IN_DONE, 8'($urandom), 1'($urandom));
  endtask

  initial begin
    int items;
    int kind;
    logic [15:0] len;
    logic [7:0] dtype;
    clk = 1'b0;
    rst = 1'b1;
    gaps_on = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    cfg_write = 1'b0;
    cfg_index = 2'd0;
    cfg_data = 8'd0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    command = CMD_SETUP;
    request_type = 8'd0;
    request_code = 8'd0;
    request_value = 16'd0;
    request_index = 16'd0;
    request_length = 16'd0;
    out_report_byte = 8'd0;
    suspended = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: every descriptor type, most requests and special cases.
    fetch_descriptor({DT_DEVICE, 8'd0}, 16'd0, 16'hFFFF, 2);
    fetch_descriptor({DT_CONFIG, 8'd0}, 16'd0, 16'd9, 1);
    fetch_descriptor({DT_REPORT, 8'd0}, 16'd0, 16'hFFFF, 4);
    fetch_descriptor({DT_REPORT, 8'd0}, 16'hFF01, 16'd64, 1);
    fetch_descriptor({DT_STRING, 8'd2}, 16'd0, 16'd255, 1);
    fetch_descriptor({DT_STRING, 8'd3}, 16'd0, 16'd255, 1);
    fetch_descriptor({8'hFF, 8'hFF}, 16'd0, 16'd64, 0);
    setup_req(RT_DEV_OUT, REQ_GET_DESC, {DT_CONFIG, 8'd0}, 16'd0, 16'd57);
    plain_event(CMD_IN_DONE, 8'd0, 1'b0);
    setup_req(RT_DEV_OUT, REQ_SET_ADDRESS, 16'h007F, 16'd0, 16'd0);
    plain_event(CMD_IN_DONE, 8'd0, 1'b0);
    setup_req(RT_DEV_OUT, REQ_SET_CONFIG, 16'h00FF, 16'd0, 16'd0);
    setup_req(RT_DEV_IN, REQ_GET_CONFIG, 16'd0, 16'd0, 16'hFFFF);
    setup_req(RT_DEV_IN, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2);
    setup_req(RT_DEV_IN, REQ_SET_ADDRESS, 16'd0, 16'd0, 16'hFFFF);
    setup_req(RT_EP_OUT, REQ_CLEAR_FEATURE, 16'd0, {8'd0, EP2_OUT}, 16'd0);
    setup_req(RT_DEV_OUT, REQ_CLEAR_FEATURE, 16'd0, {8'd0, EP1_IN}, 16'd0);
    setup_req(RT_CLASS_IFACE, REQ_SET_REPORT, 16'h0200, 16'd0, 16'd1);
    plain_event(CMD_OUT, 8'hFF, 1'b0);
    setup_req(RT_CLASS_IFACE, 8'hFF, 16'd0, 16'd0, 16'd0);
    plain_event(CMD_OUT, 8'h00, 1'b0);
    plain_event(CMD_SUSPEND, 8'd0, 1'b1);
    plain_event(CMD_SUSPEND, 8'd0, 1'b0);
    plain_event(CMD_BUS_RST, 8'd0, 1'b0);
    plain_event(3'd7, 8'd0, 1'b0);

    // Random part under several report id settings.
    gaps_on = 1'b0;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if (items == 0) write_ids(8'h00, 8'h00, 8'h00, 8'h00);
      if (items == 60) write_ids(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      if (items == 130) write_ids(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      gaps_on = (items >= 30);
      kind = $urandom_range(9);
      len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(80));
      case (kind)
        0, 1, 2: begin
          case ($urandom_range(3))
            0: dtype = DT_DEVICE;
            1: dtype = DT_CONFIG;
            2: dtype = DT_REPORT;
            default: dtype = DT_STRING;
          endcase
          fetch_descriptor({dtype, 8'($urandom_range(3))},
                           ($urandom_range(7) == 0) ? 16'($urandom) : 16'd0,
                           len, $urandom_range(5));
          items += 3;
        end
        3: begin
          setup_req(RT_DEV_OUT, REQ_SET_ADDRESS, 16'($urandom), 16'($urandom), 16'd0);
          plain_event(CMD_IN_DONE, 8'd0, 1'b0);
          items += 2;
        end
        4: begin
          setup_req(RT_CLASS_IFACE, ($urandom_range(1) != 0) ? REQ_SET_REPORT : REQ_SET_IDLE,
                    16'($urandom), 16'($urandom_range(1)), len);
          plain_event(CMD_OUT, 8'($urandom), 1'b0);
          plain_event(CMD_IN_DONE, 8'd0, 1'b0);
          items += 3;
        end
        5: begin
          case ($urandom_range(3))
            0: setup_req({1'($urandom), 7'd0}, REQ_GET_CONFIG, 16'd0, 16'd0, len);
            1: setup_req({1'($urandom), 7'd0}, REQ_GET_STATUS, 16'd0, 16'd0, len);
            2: setup_req({1'($urandom), 7'd0}, REQ_GET_IFACE, 16'd0, 16'd0, len);
            default: setup_req(RT_DEV_OUT, REQ_SET_CONFIG, 16'($urandom), 16'd0, 16'd0);
          endcase
          plain_event(CMD_IN_DONE, 8'd0, 1'b0);
          items += 2;
        end
        6: begin
          setup_req({1'($urandom), 2'd0, 5'($urandom_range(3))}, REQ_CLEAR_FEATURE,
                    16'($urandom), {8'($urandom),
                    ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2)) |
                    ($urandom_range(1) ? 8'h80 : 8'h00)}, len);
          items += 1;
        end
        7: begin
          plain_event(($urandom_range(1) != 0) ? CMD_SUSPEND : CMD_BUS_RST,
                      8'($urandom), 1'($urandom));
          items += 1;
        end
        default: begin
          // Noise: every field at random, unused commands included.
          send(3'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 8'($urandom), 1'($urandom));
          items += 1;
        end
      endcase
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    while (packets_due != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/ucer_pkg.sv
design/ucer_ctrl.sv
design/ucer_datapath.sv
design/usb_control_endpoint_responder.sv
design/ucer_checker.sv
dv/usb_control_endpoint_responder_checker.sv
dv/testbench.sv
